// ===== design/assert_macros.svh =====
// Assertion macros for the RTL of the expression lexer (used by expression_lexer.sv).
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/elx_pkg.sv =====
// Shared types and constants of the expression lexer.
// No dependencies; used by all lexer modules.
package elx_pkg;

    localparam int MaxRes = 6;
    localparam int CntW = 3;
    localparam int QueueDepth = 2;

    localparam logic [7:0] DelimReset = 8'd32;
    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharDot = 8'h2E;

    typedef struct packed {
        logic [7:0] chr;
        logic       delim;
    } res_t;

    typedef struct packed {
        logic [CntW-1:0]        count;
        logic                   eos;
        res_t [MaxRes-1:0]      res;
    } pkt_t;

endpackage

// ===== design/elx_front.sv =====
// Front end of the expression lexer: takes characters, runs the token mode
// machine and builds one packet of output bytes per character. Uses elx_pkg.
module elx_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       ch,
    input  logic             end_of_string,
    input  logic             delimiter_we,
    input  logic [7:0]       delimiter,
    input  logic             q_full,
    output logic             q_push,
    output elx_pkg::pkt_t    q_data,
    output logic             front_idle
);

    localparam logic [3:0] ModeIdle     = 4'd0;
    localparam logic [3:0] ModeAlpha    = 4'd1;
    localparam logic [3:0] ModeMinus    = 4'd2;
    localparam logic [3:0] ModeDot      = 4'd3;
    localparam logic [3:0] ModeMinusDot = 4'd4;
    localparam logic [3:0] ModeInt      = 4'd5;
    localparam logic [3:0] ModeIntWs    = 4'd6;
    localparam logic [3:0] ModeIntDot   = 4'd7;
    localparam logic [3:0] ModeFrac     = 4'd8;

    logic [3:0]    mode_reg;
    logic [3:0]    mode_next;
    logic [7:0]    delim_reg;
    logic [7:0]    delim_next;
    elx_pkg::pkt_t pkt;
    logic          accept;
    logic          c_alpha;
    logic          c_digit;
    logic          c_space;
    logic          c_punct;
    logic          c_minus;
    logic          c_dot;

    function automatic elx_pkg::pkt_t push_res(input elx_pkg::pkt_t p, input logic [7:0] c,
                                               input logic d);
        elx_pkg::pkt_t r;
        r = p;
        r.res[p.count].chr = c;
        r.res[p.count].delim = d;
        r.count = elx_pkg::CntW'(p.count + elx_pkg::CntW'(1));
        return r;
    endfunction

    assign c_alpha = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
    assign c_digit = (ch >= 8'h30 && ch <= 8'h39);
    assign c_space = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
    assign c_punct = (ch >= 8'h21 && ch <= 8'h2F) || (ch >= 8'h3A && ch <= 8'h40) ||
                     (ch >= 8'h5B && ch <= 8'h60) || (ch >= 8'h7B && ch <= 8'h7E);
    assign c_minus = (ch == elx_pkg::CharMinus);
    assign c_dot   = (ch == elx_pkg::CharDot);

    always_comb
    begin
        logic do_start;
        pkt = '0;
        pkt.eos = end_of_string;
        mode_next = mode_reg;
        do_start = 1'b0;

        unique case (mode_reg) inside
            ModeAlpha:
            begin
                if (c_alpha)
                begin
                    pkt = push_res(pkt, ch, 1'b0);
                end
                else
                begin
                    pkt = push_res(pkt, delim_reg, 1'b1);
                    do_start = 1'b1;
                end
            end
            ModeMinus:
            begin
                if (c_digit)
                begin
                    pkt = push_res(pkt, elx_pkg::CharMinus, 1'b0);
                    pkt = push_res(pkt, ch, 1'b0);
                    mode_next = ModeInt;
                end
                else if (c_dot)
                begin
                    mode_next = ModeMinusDot;
                end
                else
                begin
                    pkt = push_res(pkt, elx_pkg::CharMinus, 1'b0);
                    pkt = push_res(pkt, delim_reg, 1'b1);
                    do_start = 1'b1;
                end
            end
            ModeMinusDot:
            begin
                if (c_digit)
                begin
                    pkt = push_res(pkt, elx_pkg::CharMinus, 1'b0);
                    pkt = push_res(pkt, elx_pkg::CharDot, 1'b0);
                    pkt = push_res(pkt, ch, 1'b0);
                    mode_next = ModeFrac;
                end
                else
                begin
                    pkt = push_res(pkt, elx_pkg::CharMinus, 1'b0);
                    pkt = push_res(pkt, delim_reg, 1'b1);
                    pkt = push_res(pkt, elx_pkg::CharDot, 1'b0);
                    pkt = push_res(pkt, delim_reg, 1'b1);
                    do_start = 1'b1;
                end
            end
            ModeDot:
            begin
                if (c_digit)
                begin
                    pkt = push_res(pkt, elx_pkg::CharDot, 1'b0);
                    pkt = push_res(pkt, ch, 1'b0);
                    mode_next = ModeFrac;
                end
                else
                begin
                    pkt = push_res(pkt, elx_pkg::CharDot, 1'b0);
                    pkt = push_res(pkt, delim_reg, 1'b1);
                    do_start = 1'b1;
                end
            end
            ModeInt, ModeIntWs:
            begin
                if (mode_reg == ModeInt && c_digit)
                begin
                    pkt = push_res(pkt, ch, 1'b0);
                end
                else if (c_space)
                begin
                    mode_next = ModeIntWs;
                end
                else if (c_dot)
                begin
                    mode_next = ModeIntDot;
                end
                else
                begin
                    pkt = push_res(pkt, delim_reg, 1'b1);
                    do_start = 1'b1;
                end
            end
            ModeIntDot:
            begin
                if (c_digit)
                begin
                    pkt = push_res(pkt, elx_pkg::CharDot, 1'b0);
                    pkt = push_res(pkt, ch, 1'b0);
                    mode_next = ModeFrac;
                end
                else
                begin
                    pkt = push_res(pkt, delim_reg, 1'b1);
                    pkt = push_res(pkt, elx_pkg::CharDot, 1'b0);
                    pkt = push_res(pkt, delim_reg, 1'b1);
                    do_start = 1'b1;
                end
            end
            ModeFrac:
            begin
                if (c_digit)
                begin
                    pkt = push_res(pkt, ch, 1'b0);
                end
                else
                begin
                    pkt = push_res(pkt, delim_reg, 1'b1);
                    do_start = 1'b1;
                end
            end
            default:
            begin
                do_start = 1'b1;
            end
        endcase

        if (do_start)
        begin
            if (c_alpha)
            begin
                pkt = push_res(pkt, ch, 1'b0);
                mode_next = ModeAlpha;
            end
            else if (c_digit)
            begin
                pkt = push_res(pkt, ch, 1'b0);
                mode_next = ModeInt;
            end
            else if (c_minus)
            begin
                mode_next = ModeMinus;
            end
            else if (c_dot)
            begin
                mode_next = ModeDot;
            end
            else if (c_punct)
            begin
                pkt = push_res(pkt, ch, 1'b0);
                pkt = push_res(pkt, delim_reg, 1'b1);
                mode_next = ModeIdle;
            end
            else
            begin
                mode_next = ModeIdle;
            end
        end

        if (end_of_string)
        begin
            unique case (mode_next) inside
                ModeAlpha, ModeInt, ModeIntWs, ModeFrac:
                begin
                    pkt = push_res(pkt, delim_reg, 1'b1);
                end
                ModeMinus:
                begin
                    pkt = push_res(pkt, elx_pkg::CharMinus, 1'b0);
                    pkt = push_res(pkt, delim_reg, 1'b1);
                end
                ModeDot:
                begin
                    pkt = push_res(pkt, elx_pkg::CharDot, 1'b0);
                    pkt = push_res(pkt, delim_reg, 1'b1);
                end
                ModeMinusDot:
                begin
                    pkt = push_res(pkt, elx_pkg::CharMinus, 1'b0);
                    pkt = push_res(pkt, delim_reg, 1'b1);
                    pkt = push_res(pkt, elx_pkg::CharDot, 1'b0);
                    pkt = push_res(pkt, delim_reg, 1'b1);
                end
                ModeIntDot:
                begin
                    pkt = push_res(pkt, delim_reg, 1'b1);
                    pkt = push_res(pkt, elx_pkg::CharDot, 1'b0);
                    pkt = push_res(pkt, delim_reg, 1'b1);
                end
                default:
                begin
                end
            endcase
            mode_next = ModeIdle;
        end
    end

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign q_push     = accept && (pkt.count != '0);
    assign q_data     = pkt;
    assign front_idle = (mode_reg == ModeIdle);
    assign delim_next = delimiter_we ? delimiter : delim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ModeIdle;
            delim_reg <= elx_pkg::DelimReset;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
            end
            delim_reg <= delim_next;
        end
    end

endmodule

// ===== design/elx_queue.sv =====
// Short packet queue between the lexer front end and the output serializer.
// Uses elx_pkg for the packet type.
module elx_queue #(
    parameter int Depth = elx_pkg::QueueDepth
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  elx_pkg::pkt_t push_data,
    input  logic          pop,
    output elx_pkg::pkt_t head,
    output logic          empty,
    output logic          full
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    elx_pkg::pkt_t   mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        if (p == PtrW'(Depth - 1))
        begin
            return '0;
        end
        return PtrW'(p + PtrW'(1));
    endfunction

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CntW'(Depth));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = CntW'(cnt_reg + CntW'(1));
        end
        else if (pop && !push)
        begin
            cnt_next = CntW'(cnt_reg - CntW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== design/elx_back.sv =====
// Output serializer of the expression lexer: sends the bytes of each queued
// packet one per cycle while out_ready allows, via an output register. Uses elx_pkg.
module elx_back (
    input  logic          clk,
    input  logic          rst_n,
    input  elx_pkg::pkt_t head,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_char,
    output logic          is_delimiter,
    output logic          last_of_run,
    output logic          string_done
);

    logic [elx_pkg::CntW-1:0] idx_reg;
    logic [elx_pkg::CntW-1:0] idx_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic [7:0]               char_reg;
    logic                     delim_reg;
    logic                     last_reg;
    logic                     done_reg;
    logic                     load;
    logic                     at_last;
    logic [elx_pkg::CntW-1:0] idx_inc;

    assign idx_inc = elx_pkg::CntW'(idx_reg + elx_pkg::CntW'(1));
    assign at_last = (idx_inc == head.count);
    assign load    = !q_empty && (!valid_reg || out_ready);
    assign q_pop   = load && at_last;

    always_comb
    begin
        idx_next = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next = at_last ? '0 : idx_inc;
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg  <= head.res[idx_reg].chr;
            delim_reg <= head.res[idx_reg].delim;
            last_reg  <= at_last;
            done_reg  <= at_last && head.eos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_char     = char_reg;
    assign is_delimiter = delim_reg;
    assign last_of_run  = last_reg;
    assign string_done  = done_reg;

endmodule

// ===== design/expression_lexer.sv =====
// Expression lexer: splits a character stream into letter, number and
// punctuation tokens, each followed by the delimiter byte. A character is
// taken every cycle while the packet queue between the front end and the
// output serializer has room; the serializer sends one output byte per
// cycle while out_ready allows, so a character that yields more than one
// byte holds the output side until all its bytes are sent. Depends on elx_pkg.
`include "assert_macros.svh"

module expression_lexer #(
    parameter int QueueDepth = elx_pkg::QueueDepth
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       end_of_string,
    input  logic       delimiter_we,
    input  logic [7:0] delimiter,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       is_delimiter,
    output logic       last_of_run,
    output logic       string_done
);

    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    logic          q_full;
    logic          front_idle;
    logic          eos_accept;
    logic          done_valid;
    elx_pkg::pkt_t q_data;
    elx_pkg::pkt_t q_head;

    elx_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .end_of_string(end_of_string),
        .delimiter_we (delimiter_we),
        .delimiter    (delimiter),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_data),
        .front_idle   (front_idle)
    );

    elx_queue #(
        .Depth(QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_data),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    elx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .is_delimiter(is_delimiter),
        .last_of_run (last_of_run),
        .string_done (string_done)
    );

    assign eos_accept = in_valid && in_ready && end_of_string;
    assign done_valid = out_valid && string_done;

    // The front end never writes a full queue, and the serializer never
    // reads an empty one.
    `ASSERT_IMPLY(a_no_overflow, clk, rst_n, q_push, !q_full, "push into a full queue")
    `ASSERT_IMPLY(a_no_underflow, clk, rst_n, q_pop, !q_empty, "pop from an empty queue")
    `ASSERT_NEXT(a_eos_idle, clk, rst_n, eos_accept, front_idle, "not idle after end of string")
    `ASSERT_IMPLY(a_done_is_last, clk, rst_n, done_valid, last_of_run, "done without last of run")

endmodule

// ===== bench/lexer_checker.sv =====
// Scoreboard for the expression lexer: watches the character, delimiter and
// output channels, predicts every output byte and compares it with the block.
// Depends on elx_pkg for the delimiter reset value and the '-' and '.' codes.
module lexer_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] ch,
    input  logic       end_of_string,
    input  logic       delimiter_we,
    input  logic [7:0] delimiter,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_char,
    input  logic       is_delimiter,
    input  logic       last_of_run,
    input  logic       string_done,
    output int         failures,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        LxIdle,
        LxAlpha,
        LxMinus,
        LxDot,
        LxMinusDot,
        LxInt,
        LxIntWs,
        LxIntDot,
        LxFrac
    } lex_mode_e;

    typedef struct packed {
        logic [7:0] chr;
        logic       delim;
        logic       last;
        logic       done;
    } lex_byte_t;

    lex_mode_e  lex_mode = LxIdle;
    logic [7:0] delim_byte = elx_pkg::DelimReset;
    lex_byte_t  expected_bytes[$];
    lex_byte_t  step_bytes[$];

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    task automatic emit(input logic [7:0] c, input logic is_delim);
        lex_byte_t b;
        b.chr = c;
        b.delim = is_delim;
        b.last = 1'b0;
        b.done = 1'b0;
        step_bytes.push_back(b);
    endtask

    task automatic emit_delim();
        emit(delim_byte, 1'b1);
    endtask

    task automatic open_token(input logic [7:0] c);
        if (is_letter(c))
        begin
            emit(c, 1'b0);
            lex_mode = LxAlpha;
        end
        else if (is_digit(c))
        begin
            emit(c, 1'b0);
            lex_mode = LxInt;
        end
        else if (c == elx_pkg::CharMinus)
            lex_mode = LxMinus;
        else if (c == elx_pkg::CharDot)
            lex_mode = LxDot;
        else if (is_punct(c))
        begin
            emit(c, 1'b0);
            emit_delim();
            lex_mode = LxIdle;
        end
        else
            lex_mode = LxIdle;
    endtask

    task automatic tokenize_char(input logic [7:0] c, input logic eos);
        step_bytes.delete();
        case (lex_mode)
            LxAlpha:
            begin
                if (is_letter(c))
                    emit(c, 1'b0);
                else
                begin
                    emit_delim();
                    open_token(c);
                end
            end
            LxMinus:
            begin
                if (is_digit(c))
                begin
                    emit(elx_pkg::CharMinus, 1'b0);
                    emit(c, 1'b0);
                    lex_mode = LxInt;
                end
                else if (c == elx_pkg::CharDot)
                    lex_mode = LxMinusDot;
                else
                begin
                    emit(elx_pkg::CharMinus, 1'b0);
                    emit_delim();
                    open_token(c);
                end
            end
            LxMinusDot:
            begin
                emit(elx_pkg::CharMinus, 1'b0);
                if (is_digit(c))
                begin
                    emit(elx_pkg::CharDot, 1'b0);
                    emit(c, 1'b0);
                    lex_mode = LxFrac;
                end
                else
                begin
                    emit_delim();
                    emit(elx_pkg::CharDot, 1'b0);
                    emit_delim();
                    open_token(c);
                end
            end
            LxDot:
            begin
                emit(elx_pkg::CharDot, 1'b0);
                if (is_digit(c))
                begin
                    emit(c, 1'b0);
                    lex_mode = LxFrac;
                end
                else
                begin
                    emit_delim();
                    open_token(c);
                end
            end
            LxInt, LxIntWs:
            begin
                if (lex_mode == LxInt && is_digit(c))
                    emit(c, 1'b0);
                else if (is_space(c))
                    lex_mode = LxIntWs;
                else if (c == elx_pkg::CharDot)
                    lex_mode = LxIntDot;
                else
                begin
                    emit_delim();
                    open_token(c);
                end
            end
            LxIntDot:
            begin
                if (is_digit(c))
                begin
                    emit(elx_pkg::CharDot, 1'b0);
                    emit(c, 1'b0);
                    lex_mode = LxFrac;
                end
                else
                begin
                    emit_delim();
                    emit(elx_pkg::CharDot, 1'b0);
                    emit_delim();
                    open_token(c);
                end
            end
            LxFrac:
            begin
                if (is_digit(c))
                    emit(c, 1'b0);
                else
                begin
                    emit_delim();
                    open_token(c);
                end
            end
            default:
                open_token(c);
        endcase

        // At the end of a string every open or pending token is closed.
        if (eos)
        begin
            case (lex_mode)
                LxAlpha, LxInt, LxIntWs, LxFrac:
                    emit_delim();
                LxMinus:
                begin
                    emit(elx_pkg::CharMinus, 1'b0);
                    emit_delim();
                end
                LxDot:
                begin
                    emit(elx_pkg::CharDot, 1'b0);
                    emit_delim();
                end
                LxMinusDot:
                begin
                    emit(elx_pkg::CharMinus, 1'b0);
                    emit_delim();
                    emit(elx_pkg::CharDot, 1'b0);
                    emit_delim();
                end
                LxIntDot:
                begin
                    emit_delim();
                    emit(elx_pkg::CharDot, 1'b0);
                    emit_delim();
                end
                default:
                    ;
            endcase
            lex_mode = LxIdle;
        end

        foreach (step_bytes[k])
        begin
            if (k == step_bytes.size() - 1)
            begin
                step_bytes[k].last = 1'b1;
                step_bytes[k].done = eos;
            end
            expected_bytes.push_back(step_bytes[k]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lex_byte_t want;
        if (!rst_n)
        begin
            lex_mode = LxIdle;
            delim_byte = elx_pkg::DelimReset;
            expected_bytes.delete();
            failures = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("out_char: no byte expected, actual 0x%02h", out_char);
                    failures++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_char !== want.chr)
                    begin
                        $error("out_char: expected 0x%02h, actual 0x%02h", want.chr, out_char);
                        failures++;
                    end
                    if (is_delimiter !== want.delim)
                    begin
                        $error("is_delimiter: expected %0b, actual %0b", want.delim,
                               is_delimiter);
                        failures++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0b, actual %0b", want.last,
                               last_of_run);
                        failures++;
                    end
                    if (string_done !== want.done)
                    begin
                        $error("string_done: expected %0b, actual %0b", want.done,
                               string_done);
                        failures++;
                    end
                end
            end
            if (delimiter_we)
                delim_byte = delimiter;
            if (in_valid && in_ready)
                tokenize_char(ch, end_of_string);
        end
        pending = expected_bytes.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the expression lexer bench: clock, reset, character stimulus,
// output back-pressure, delimiter changes and the final verdict.
// Depends on elx_pkg, expression_lexer and lexer_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HalfPeriod = 5;
    localparam int ResetCycles = 9;
    localparam int SettleCycles = 8;
    localparam int LongHoldOff = 120;
    localparam int IdleLimit = 2000;
    localparam int PhaseItems = 45;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] ch = 8'h00;
    logic       end_of_string = 1'b0;
    logic       delimiter_we = 1'b0;
    logic [7:0] delimiter = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_char;
    logic       is_delimiter;
    logic       last_of_run;
    logic       string_done;

    int         failures;
    int         pending;
    int         idle_cycles = 0;
    int         hold_off_requests = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;
    logic [7:0] expr_chars[$];

    expression_lexer i_dut (
        .clk,
        .rst_n,
        .in_valid,
        .in_ready,
        .ch,
        .end_of_string,
        .delimiter_we,
        .delimiter,
        .out_valid,
        .out_ready,
        .out_char,
        .is_delimiter,
        .last_of_run,
        .string_done
    );

    lexer_checker i_checker (
        .clk,
        .rst_n,
        .in_valid,
        .in_ready,
        .ch,
        .end_of_string,
        .delimiter_we,
        .delimiter,
        .out_valid,
        .out_ready,
        .out_char,
        .is_delimiter,
        .last_of_run,
        .string_done,
        .failures,
        .pending
    );

    always #HalfPeriod clk = ~clk;

    initial
    begin
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int gap_length();
        int pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eos);
        int gap;
        gap = tx_calm ? 0 : gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        end_of_string <= eos;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_delimiter(input logic [7:0] value);
        delimiter_we <= 1'b1;
        delimiter <= value;
        @(posedge clk);
        delimiter_we <= 1'b0;
    endtask

    // Mostly well-formed expressions; a few noise bytes and stray '-' or '.'.
    task automatic build_expression();
        int         kind;
        int         digits;
        logic [7:0] c;
        expr_chars.delete();
        repeat ($urandom_range(1, 6))
        begin
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                if ($urandom_range(0, 2) == 0)
                    expr_chars.push_back(elx_pkg::CharMinus);
                digits = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
                repeat (digits) expr_chars.push_back(8'($urandom_range(8'h30, 8'h39)));
                if (digits == 0 || $urandom_range(0, 1) == 1)
                begin
                    if (digits > 0)
                        repeat ($urandom_range(0, 2))
                            expr_chars.push_back(8'($urandom_range(8'h09, 8'h0D)));
                    expr_chars.push_back(elx_pkg::CharDot);
                    repeat ($urandom_range(1, 2))
                        expr_chars.push_back(8'($urandom_range(8'h30, 8'h39)));
                end
            end
            else if (kind < 50)
            begin
                repeat ($urandom_range(1, 4))
                    expr_chars.push_back($urandom_range(0, 1) ?
                                         8'($urandom_range(8'h41, 8'h5A)) :
                                         8'($urandom_range(8'h61, 8'h7A)));
            end
            else if (kind < 75)
            begin
                do
                    c = 8'($urandom_range(8'h21, 8'h7E));
                while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                       (c >= 8'h61 && c <= 8'h7A));
                expr_chars.push_back(c);
            end
            else if (kind < 87)
                expr_chars.push_back($urandom_range(0, 1) ? 8'h20 :
                                     8'($urandom_range(8'h09, 8'h0D)));
            else if (kind < 93)
                expr_chars.push_back(8'($urandom()));
            else
            begin
                repeat ($urandom_range(1, 2))
                    expr_chars.push_back($urandom_range(0, 1) ? elx_pkg::CharMinus :
                                         elx_pkg::CharDot);
            end
        end
    endtask

    initial
    begin
        int stall_left;
        int served;
        stall_left = 0;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (served != hold_off_requests)
            begin
                served = hold_off_requests;
                stall_left = LongHoldOff - 1;
                out_ready <= 1'b0;
            end
            else if (!rx_calm && $urandom_range(0, 3) == 0)
            begin
                stall_left = gap_length();
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || delimiter_we)
            idle_cycles <= 0;
        else if (idle_cycles >= IdleLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int         sent;
        logic [7:0] phase_delim[4];
        wait (rst_n);
        @(posedge clk);

        send_char("Z", 1'b0);
        send_char("z", 1'b0);
        send_char(elx_pkg::CharMinus, 1'b0);
        send_char("9", 1'b0);
        send_char(" ", 1'b0);
        send_char(elx_pkg::CharDot, 1'b0);
        send_char("5", 1'b0);
        send_char(elx_pkg::CharMinus, 1'b0);
        send_char(elx_pkg::CharDot, 1'b0);
        send_char("x", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(elx_pkg::CharDot, 1'b0);
        send_char("@", 1'b0);
        send_char("0", 1'b0);
        send_char(elx_pkg::CharDot, 1'b0);
        send_char("(", 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(elx_pkg::CharMinus, 1'b0);
        send_char(elx_pkg::CharDot, 1'b1);
        send_char("3", 1'b0);
        send_char(elx_pkg::CharDot, 1'b1);
        send_char(elx_pkg::CharMinus, 1'b1);
        send_char(elx_pkg::CharDot, 1'b0);
        send_char("1", 1'b1);
        send_char("8", 1'b0);
        send_char(8'h09, 1'b0);
        send_char("A", 1'b1);

        phase_delim[0] = 8'h00;
        phase_delim[1] = 8'hFF;
        phase_delim[2] = 8'($urandom_range(0, 255));
        phase_delim[3] = elx_pkg::CharDot;
        for (int p = 0; p < 4; p++)
        begin
            wait_for_drain();
            write_delimiter(phase_delim[p]);
            tx_calm = (p == 1 || p == 2);
            rx_calm = (p == 1);
            sent = 0;
            while (sent < PhaseItems)
            begin
                build_expression();
                foreach (expr_chars[k])
                    send_char(expr_chars[k], k == expr_chars.size() - 1);
                sent += expr_chars.size();
                // The output side stops for a long stretch while characters keep coming.
                if (p == 2 && hold_off_requests == 0 && sent > 10)
                    hold_off_requests++;
            end
        end

        wait_for_drain();
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
